[rtl/mfl_pkg.sv]
// mfl_pkg: shared types, constants and helpers for the message flood limiter.
// Used by every module in rtl/. No dependencies.
`default_nettype none

package mfl_pkg;

    localparam int TIME_W = 48;   // millisecond time stamps
    localparam int SEC_W  = 20;   // second counts
    localparam int MS_W   = 30;   // clamped seconds times 1000 fits in 30 bits
    localparam int IDX_W  = 2;    // config register index
    localparam int MAXM_W = 4;    // max_messages register

    localparam logic [SEC_W-1:0]  SECONDS_MAX = 20'd999999;
    localparam logic [MS_W-1:0]   MS_PER_S    = 30'd1000;
    // Lock remainder at or above this many ms reports SECONDS_MAX.
    localparam logic [TIME_W-1:0] WAIT_CLAMP_MS = 48'd999999000;

    // floor(d / 1000) == (d * DIV_MULT) >> DIV_SHIFT, exact for d < 2^30.
    localparam int                DIV_MULT_W = 31;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 31'd1099511628;
    localparam int                DIV_SHIFT  = 40;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_MAX_MESSAGES    = 2'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_SECONDS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SILENCE_SECONDS = 2'd2;

    // Register reset values.
    localparam logic [MAXM_W-1:0] MAX_MESSAGES_RST    = 4'd4;
    localparam logic [SEC_W-1:0]  WINDOW_SECONDS_RST  = 20'd2;
    localparam logic [SEC_W-1:0]  SILENCE_SECONDS_RST = 20'd2;

    // Verdict codes.
    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_LOCKED = 2'd1;
    localparam logic [1:0] VERDICT_NEW    = 2'd2;

    // Effective configuration, already clamped and scaled.
    typedef struct packed {
        logic [MAXM_W-1:0] max_eff;
        logic [MS_W-1:0]   window_ms;
        logic [SEC_W-1:0]  silence_s;
        logic [MS_W-1:0]   silence_ms;
    } t_cfg;

    function automatic logic [SEC_W-1:0] clamp_seconds(input logic [SEC_W-1:0] v);
        logic [SEC_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = 20'd1;
        end else if (v > SECONDS_MAX) begin
            r = SECONDS_MAX;
        end
        return r;
    endfunction

    // Constant multiply, shift-and-add in synthesis.
    function automatic logic [MS_W-1:0] to_ms(input logic [SEC_W-1:0] s);
        return MS_W'(s) * MS_PER_S;
    endfunction

endpackage

`default_nettype wire

[rtl/message_flood_limiter.sv]
// message_flood_limiter: sliding-window flood limiter, one verdict per request.
// Input, stage 2 and output registers; one request per cycle while not stalled.
// The decision stage reads the prefetched ring slot, compares times and updates
// ring, slot and lock state in the same cycle; the wait divide sits one stage later.
// Reset (sync, active low) empties the pipe, clears the ring valid bits, slot and
// lock end, and restores max_messages=4, window_seconds=2, silence_seconds=2.
`default_nettype none

module message_flood_limiter #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // request channel
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [47:0]                i_s_tdata,   // [47:0] now_ms
    // result channel
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic      [23:0]                o_m_tdata,   // [0] rejected, [2:1] verdict,
                                                         // [22:3] wait_seconds, [23] zero
    // configuration writes
    input  wire logic                       i_cfg_we,
    input  wire logic [mfl_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mfl_pkg::SEC_W-1:0]  i_cfg_data
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int CMP_W  = (SLOT_W + 1 > mfl_pkg::MAXM_W) ? SLOT_W + 1 : mfl_pkg::MAXM_W;
    localparam int TW     = mfl_pkg::TIME_W;

    mfl_pkg::t_cfg cfg;

    mfl_cfg #(
        .RING_DEPTH (RING_DEPTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // ---------------------------------------------------------------
    // Handshake: a single stall chain from the output register back.
    // ---------------------------------------------------------------
    logic r_s1_vld, r_s2_vld, r_out_vld;
    logic out_rdy, s2_rdy, adv1;

    assign out_rdy    = !r_out_vld || i_m_tready;
    assign s2_rdy     = !r_s2_vld || out_rdy;
    assign adv1       = r_s1_vld && s2_rdy;
    assign o_s_tready = !r_s1_vld || s2_rdy;

    // Input register
    logic [TW-1:0] r_s1_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_now <= i_s_tdata;
        end
    end

    // ---------------------------------------------------------------
    // Decision stage: lock check, window check, ring and lock update.
    // ---------------------------------------------------------------
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [TW-1:0]     r_lock;
    logic [TW-1:0]     stamp;
    logic              stamp_vld;

    logic              locked, hit, accept;
    logic [TW-1:0]     lock_rem, age;
    logic [TW:0]       end_sum;
    logic [TW-1:0]     end_sat;
    logic [SLOT_W:0]   slot_inc;
    logic              wrap;
    logic [1:0]        verdict;

    assign locked   = r_s1_now < r_lock;
    assign lock_rem = r_lock - r_s1_now;
    assign age      = r_s1_now - stamp;
    // stamp later than now counts as outside the window
    assign hit      = stamp_vld && (stamp != '0) && (r_s1_now >= stamp)
                      && (age < TW'(cfg.window_ms));
    assign accept   = adv1 && !locked && !hit;

    assign end_sum  = {1'b0, r_s1_now} + (TW + 1)'(cfg.silence_ms);
    assign end_sat  = end_sum[TW] ? '1 : end_sum[TW-1:0];

    assign slot_inc = {1'b0, r_slot} + (SLOT_W + 1)'(1);
    assign wrap     = CMP_W'(slot_inc) >= CMP_W'(cfg.max_eff);
    assign n_slot   = accept ? (wrap ? '0 : slot_inc[SLOT_W-1:0]) : r_slot;

    always_comb begin
        priority if (locked) begin
            verdict = mfl_pkg::VERDICT_LOCKED;
        end else if (hit) begin
            verdict = mfl_pkg::VERDICT_NEW;
        end else begin
            verdict = mfl_pkg::VERDICT_ACCEPT;
        end
    end

    mfl_ring #(
        .RING_DEPTH (RING_DEPTH),
        .SLOT_W     (SLOT_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept),
        .i_waddr (r_slot),
        .i_wdata (r_s1_now),
        .i_raddr (n_slot),
        .o_rdata (stamp),
        .o_rvld  (stamp_vld)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_lock <= '0;
        end else begin
            r_slot <= n_slot;
            if (adv1 && !locked && hit) begin
                r_lock <= end_sat;
            end
        end
    end

    // Stage 2 register: verdict, over-range flag and truncated lock remainder
    logic [1:0]                r_s2_verdict;
    logic                      r_s2_big;
    logic [mfl_pkg::MS_W-1:0]  r_s2_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_rdy) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s2_verdict <= verdict;
            r_s2_big     <= lock_rem >= mfl_pkg::WAIT_CLAMP_MS;
            r_s2_rem     <= lock_rem[mfl_pkg::MS_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Wait seconds and output register.
    // ---------------------------------------------------------------
    logic [mfl_pkg::SEC_W-1:0] wait_s;

    mfl_wait u_wait (
        .i_verdict   (r_s2_verdict),
        .i_big       (r_s2_big),
        .i_rem_ms    (r_s2_rem),
        .i_silence_s (cfg.silence_s),
        .o_wait_s    (wait_s)
    );

    logic                      r_out_rej;
    logic [1:0]                r_out_verdict;
    logic [mfl_pkg::SEC_W-1:0] r_out_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_rdy) begin
            r_out_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_s2_vld) begin
            r_out_rej     <= r_s2_verdict != mfl_pkg::VERDICT_ACCEPT;
            r_out_verdict <= r_s2_verdict;
            r_out_wait    <= wait_s;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out_wait, r_out_verdict, r_out_rej};

endmodule

`default_nettype wire

[rtl/mfl_cfg.sv]
// mfl_cfg: configuration registers, stored in clamped and pre-scaled form.
// Depends on mfl_pkg.
`default_nettype none

module mfl_cfg #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [mfl_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mfl_pkg::SEC_W-1:0]  i_cfg_data,
    output mfl_pkg::t_cfg                   o_cfg
);

    localparam int MAX_LIM_I = (RING_DEPTH - 1 > 15) ? 15 : RING_DEPTH - 1;
    localparam logic [mfl_pkg::MAXM_W-1:0] MAX_LIM = mfl_pkg::MAXM_W'(MAX_LIM_I);

    function automatic logic [mfl_pkg::MAXM_W-1:0] clamp_max(
        input logic [mfl_pkg::MAXM_W-1:0] m
    );
        logic [mfl_pkg::MAXM_W-1:0] r;
        r = m;
        if (m == '0) begin
            r = 4'd1;
        end else if (m > MAX_LIM) begin
            r = MAX_LIM;
        end
        return r;
    endfunction

    mfl_pkg::t_cfg r_cfg;
    logic [mfl_pkg::SEC_W-1:0] wr_sec;

    assign wr_sec = mfl_pkg::clamp_seconds(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_eff    <= clamp_max(mfl_pkg::MAX_MESSAGES_RST);
            r_cfg.window_ms  <= mfl_pkg::to_ms(mfl_pkg::WINDOW_SECONDS_RST);
            r_cfg.silence_s  <= mfl_pkg::SILENCE_SECONDS_RST;
            r_cfg.silence_ms <= mfl_pkg::to_ms(mfl_pkg::SILENCE_SECONDS_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mfl_pkg::REG_MAX_MESSAGES: begin
                    r_cfg.max_eff <= clamp_max(i_cfg_data[mfl_pkg::MAXM_W-1:0]);
                end
                mfl_pkg::REG_WINDOW_SECONDS: begin
                    r_cfg.window_ms <= mfl_pkg::to_ms(wr_sec);
                end
                mfl_pkg::REG_SILENCE_SECONDS: begin
                    r_cfg.silence_s  <= wr_sec;
                    r_cfg.silence_ms <= mfl_pkg::to_ms(wr_sec);
                end
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/mfl_ring.sv]
// mfl_ring: ring of accepted time stamps with per-entry valid bits and a
// registered prefetch of the slot the next request will use. Depends on mfl_pkg.
`default_nettype none

module mfl_ring #(
    parameter int RING_DEPTH = 16,
    parameter int SLOT_W     = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_we,
    input  wire logic [SLOT_W-1:0]           i_waddr,
    input  wire logic [mfl_pkg::TIME_W-1:0]  i_wdata,
    input  wire logic [SLOT_W-1:0]           i_raddr,   // slot for the next request
    output logic      [mfl_pkg::TIME_W-1:0]  o_rdata,   // zero when never written
    output logic                             o_rvld
);

    logic [mfl_pkg::TIME_W-1:0] mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]      r_valid;
    logic [mfl_pkg::TIME_W-1:0] r_rd;
    logic                       r_rd_vld;
    logic                       fwd;

    assign fwd = i_we && (i_raddr == i_waddr);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd <= fwd ? i_wdata : mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_vld <= fwd || r_valid[i_raddr];
        end
    end

    assign o_rvld  = r_rd_vld;
    assign o_rdata = r_rd_vld ? r_rd : '0;

endmodule

`default_nettype wire

[rtl/mfl_wait.sv]
// mfl_wait: forms the reported wait_seconds from the decision stage's outputs;
// remaining lock ms are divided by 1000 through a reciprocal multiply. Depends on mfl_pkg.
`default_nettype none

module mfl_wait (
    input  wire logic [1:0]                 i_verdict,
    input  wire logic                       i_big,       // remainder beyond range
    input  wire logic [mfl_pkg::MS_W-1:0]   i_rem_ms,
    input  wire logic [mfl_pkg::SEC_W-1:0]  i_silence_s,
    output logic      [mfl_pkg::SEC_W-1:0]  o_wait_s
);

    localparam int PROD_W = mfl_pkg::MS_W + mfl_pkg::DIV_MULT_W;

    logic [PROD_W-1:0]         prod;
    logic [mfl_pkg::SEC_W-1:0] quot;

    assign prod = PROD_W'(i_rem_ms) * PROD_W'(mfl_pkg::DIV_MULT);
    assign quot = prod[mfl_pkg::DIV_SHIFT +: mfl_pkg::SEC_W];

    always_comb begin
        unique case (i_verdict)
            mfl_pkg::VERDICT_LOCKED: o_wait_s = i_big ? mfl_pkg::SECONDS_MAX : quot;
            mfl_pkg::VERDICT_NEW:    o_wait_s = i_silence_s;
            default:                 o_wait_s = '0;
        endcase
    end

endmodule

`default_nettype wire
